@@ rtl/cbtr_pkg.sv @@
`timescale 1ns / 1ps

package cbtr_pkg;

  typedef enum logic [3:0] {
    PH_SYNC = 4'b0001,
    PH_SEG1 = 4'b0010,
    PH_SEG2 = 4'b0100,
    PH_WIN  = 4'b1000
  } phase_t;

  localparam logic [1:0] CODE_SYNC = 2'd0;
  localparam logic [1:0] CODE_SEG1 = 2'd1;
  localparam logic [1:0] CODE_SEG2 = 2'd2;
  localparam logic [1:0] CODE_WIN  = 2'd3;

  localparam logic [1:0] REG_SEG1_QUANTA = 2'd0;
  localparam logic [1:0] REG_SEG2_QUANTA = 2'd1;
  localparam logic [1:0] REG_JUMP_WIDTH  = 2'd2;
  localparam logic [1:0] REG_SELF_EDGE   = 2'd3;

  localparam logic [4:0] SEG1_QUANTA_RST = 5'd7;
  localparam logic [4:0] SEG2_QUANTA_RST = 5'd7;
  localparam logic [2:0] JUMP_WIDTH_RST  = 3'd2;

  localparam logic [4:0] SELF_EDGE_COUNT = 5'd2;
  localparam logic [4:0] SEG_LIMIT_MAX   = 5'd30;
  localparam logic [4:0] SEG_COUNT_MAX   = 5'd31;
  localparam logic [1:0] SYNC_COUNT_MAX  = 2'd3;

  typedef struct packed {
    logic [1:0] phase;
    logic       write_mark;
    logic       sample_mark;
  } result_t;

  function automatic logic [4:0] clamp_limit(input logic [5:0] v);
    logic [4:0] r;
    if (v > {1'b0, SEG_LIMIT_MAX}) begin
      r = SEG_LIMIT_MAX;
    end else begin
      r = v[4:0];
    end
    return r;
  endfunction

  function automatic logic [1:0] phase_code(input phase_t p);
    logic [1:0] c;
    case (p)
      PH_SYNC: c = CODE_SYNC;
      PH_SEG1: c = CODE_SEG1;
      PH_SEG2: c = CODE_SEG2;
      PH_WIN:  c = CODE_WIN;
      default: c = CODE_SYNC;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/can_bit_timing_resync_unit.sv @@
`timescale 1ns / 1ps

// CAN bit timing with resynchronization.
// Input channel: one word per time quantum (in_edge_seen), in_valid/in_stall.
// Result channel: one word per quantum (out_phase, out_write_mark,
// out_sample_mark), out_valid/out_stall.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
// 0 seg1_quanta, 1 seg2_quanta, 2 jump_width, 3 self_edge_enable.
// cfg_ready is always high; write only while the block is idle.
// Each result word is registered into the result register, or into the skid register while the receiver stalls.
// Throughput: one quantum per cycle while in_stall is low; the whole timing update is one pass
// of logic from the state registers into the result (or skid) register.
// A one-word skid register sits behind the result register, so a new
// quantum is still taken in the cycle the receiver first stalls; in_stall
// rises only once both are full and falls when the receiver drains.
// Reset (synchronous, rst_n low): phase sync, counters restarted, no
// pending edge, both output registers empty, config at its defaults
// (7, 7, 2, 1).
module can_bit_timing_resync_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_edge_seen,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_phase,
  output logic       out_write_mark,
  output logic       out_sample_mark,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_data
);

  logic [4:0] seg1_quanta_r;
  logic [4:0] seg2_quanta_r;
  logic [2:0] jump_width_r;
  logic       self_edge_en_r;

  cbtr_pkg::phase_t phase_r, phase_nxt;
  logic [1:0] sync_cnt_r, sync_cnt_nxt;
  logic [4:0] seg1_cnt_r, seg1_cnt_nxt;
  logic [4:0] seg2_cnt_r, seg2_cnt_nxt;
  logic [2:0] lengthen_r, lengthen_nxt;
  logic [2:0] shorten_r, shorten_nxt;
  logic       edge_pend_r, edge_pend_nxt;
  logic       write_flag_r, write_flag_nxt;
  logic       sample_flag_r, sample_flag_nxt;

  cbtr_pkg::result_t out_word_r, skid_word_r, new_word;
  logic out_valid_r, skid_valid_r;
  logic in_acc, out_take, out_free;

  logic [4:0] lim1, lim2, limw, left;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid & ~in_stall;
  assign out_take  = out_valid_r & ~out_stall;
  assign out_free  = ~out_valid_r | out_take;

  assign lim1 = cbtr_pkg::clamp_limit({1'b0, seg1_quanta_r} + {3'b000, lengthen_r});
  assign lim2 = cbtr_pkg::clamp_limit({1'b0, seg2_quanta_r});
  assign limw = ({2'b00, shorten_r} > seg2_quanta_r) ? 5'd0 :
                cbtr_pkg::clamp_limit({1'b0, seg2_quanta_r - {2'b00, shorten_r}});

  always_comb begin
    phase_nxt       = phase_r;
    sync_cnt_nxt    = sync_cnt_r;
    seg1_cnt_nxt    = seg1_cnt_r;
    seg2_cnt_nxt    = seg2_cnt_r;
    lengthen_nxt    = lengthen_r;
    shorten_nxt     = shorten_r;
    edge_pend_nxt   = edge_pend_r | in_edge_seen;
    write_flag_nxt  = write_flag_r;
    sample_flag_nxt = sample_flag_r;
    left            = 5'd0;

    // advance the counter of the current phase
    case (phase_r)
      cbtr_pkg::PH_SYNC: begin
        if (sync_cnt_r != cbtr_pkg::SYNC_COUNT_MAX) sync_cnt_nxt = sync_cnt_r + 2'd1;
      end
      cbtr_pkg::PH_SEG1: begin
        if (seg1_cnt_r != cbtr_pkg::SEG_COUNT_MAX) seg1_cnt_nxt = seg1_cnt_r + 5'd1;
      end
      default: begin
        if (seg2_cnt_r != cbtr_pkg::SEG_COUNT_MAX) seg2_cnt_nxt = seg2_cnt_r + 5'd1;
      end
    endcase

    // evaluate the phase
    case (phase_r)
      cbtr_pkg::PH_SYNC: begin
        if (sync_cnt_nxt == 2'd1) begin
          phase_nxt      = cbtr_pkg::PH_SEG1;
          write_flag_nxt = 1'b1;
        end
      end
      cbtr_pkg::PH_SEG1: begin
        if (seg1_cnt_nxt <= lim1) begin
          write_flag_nxt = 1'b0;
        end else begin
          phase_nxt       = cbtr_pkg::PH_SEG2;
          sample_flag_nxt = 1'b1;
        end
      end
      cbtr_pkg::PH_SEG2: begin
        if (self_edge_en_r && seg2_cnt_nxt == cbtr_pkg::SELF_EDGE_COUNT) begin
          edge_pend_nxt = 1'b1;
        end
        if (seg2_cnt_nxt <= lim2) begin
          sample_flag_nxt = 1'b0;
        end else begin
          phase_nxt      = cbtr_pkg::PH_SYNC;
          sync_cnt_nxt   = 2'd0;
          seg1_cnt_nxt   = 5'd1;
          seg2_cnt_nxt   = 5'd1;
          lengthen_nxt   = 3'd0;
          shorten_nxt    = 3'd0;
          write_flag_nxt = 1'b0;
        end
      end
      default: begin
        if (seg2_cnt_nxt > limw) begin
          phase_nxt      = cbtr_pkg::PH_SEG1;
          sync_cnt_nxt   = 2'd0;
          seg1_cnt_nxt   = 5'd1;
          seg2_cnt_nxt   = 5'd1;
          lengthen_nxt   = 3'd0;
          shorten_nxt    = 3'd0;
          write_flag_nxt = 1'b0;
        end
      end
    endcase

    // apply a pending edge
    if (edge_pend_nxt) begin
      if (phase_nxt == cbtr_pkg::PH_SEG1) begin
        lengthen_nxt  = (seg1_cnt_nxt > {2'b00, jump_width_r}) ? jump_width_r
                                                               : seg1_cnt_nxt[2:0];
        edge_pend_nxt = 1'b0;
      end else if (phase_nxt == cbtr_pkg::PH_SEG2) begin
        left          = (seg2_quanta_r > seg2_cnt_nxt) ? seg2_quanta_r - seg2_cnt_nxt
                                                       : 5'd0;
        shorten_nxt   = (left > {2'b00, jump_width_r}) ? jump_width_r : left[2:0];
        phase_nxt     = cbtr_pkg::PH_WIN;
        edge_pend_nxt = 1'b0;
      end
    end

    new_word.phase       = cbtr_pkg::phase_code(phase_nxt);
    new_word.write_mark  = write_flag_nxt;
    new_word.sample_mark = sample_flag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg1_quanta_r  <= cbtr_pkg::SEG1_QUANTA_RST;
      seg2_quanta_r  <= cbtr_pkg::SEG2_QUANTA_RST;
      jump_width_r   <= cbtr_pkg::JUMP_WIDTH_RST;
      self_edge_en_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cbtr_pkg::REG_SEG1_QUANTA: seg1_quanta_r  <= cfg_data;
        cbtr_pkg::REG_SEG2_QUANTA: seg2_quanta_r  <= cfg_data;
        cbtr_pkg::REG_JUMP_WIDTH:  jump_width_r   <= cfg_data[2:0];
        cbtr_pkg::REG_SELF_EDGE:   self_edge_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= cbtr_pkg::PH_SYNC;
      sync_cnt_r    <= 2'd0;
      seg1_cnt_r    <= 5'd1;
      seg2_cnt_r    <= 5'd1;
      lengthen_r    <= 3'd0;
      shorten_r     <= 3'd0;
      edge_pend_r   <= 1'b0;
      write_flag_r  <= 1'b0;
      sample_flag_r <= 1'b0;
    end else if (in_acc) begin
      phase_r       <= phase_nxt;
      sync_cnt_r    <= sync_cnt_nxt;
      seg1_cnt_r    <= seg1_cnt_nxt;
      seg2_cnt_r    <= seg2_cnt_nxt;
      lengthen_r    <= lengthen_nxt;
      shorten_r     <= shorten_nxt;
      edge_pend_r   <= edge_pend_nxt;
      write_flag_r  <= write_flag_nxt;
      sample_flag_r <= sample_flag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r | in_acc;
      skid_valid_r <= 1'b0;
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_word_r <= skid_word_r;
      end else if (in_acc) begin
        out_word_r <= new_word;
      end
    end else if (in_acc) begin
      skid_word_r <= new_word;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_phase       = out_word_r.phase;
  assign out_write_mark  = out_word_r.write_mark;
  assign out_sample_mark = out_word_r.sample_mark;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held while result register empty");

  a_accept_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !out_valid_r) |=> out_valid_r)
    else $error("accepted quantum did not reach result register");

  a_sync_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == cbtr_pkg::PH_SYNC) |-> (sync_cnt_r == 2'd0))
    else $error("sync phase entered without counter restart");

  a_seg_counts_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (seg1_cnt_r != 5'd0) && (seg2_cnt_r != 5'd0))
    else $error("segment counter dropped to zero");

endmodule

@@ sim/can_bit_timing_resync_unit_tb.sv @@
`timescale 1ns / 1ps

module can_bit_timing_resync_unit_tb;
  import cbtr_pkg::*;

  localparam int HANDSHAKE_LIMIT = 2000;
  localparam int PHASE_QUANTA    = 56;
  localparam int RANDOM_SETTINGS = 5;

  typedef struct packed {
    logic    edge_in;
    logic    known;
    result_t res;
  } stim_row_t;

  typedef struct packed {
    logic [4:0] seg1;
    logic [4:0] seg2;
    logic [2:0] sjw;
    logic       self_en;
  } timing_cfg_t;

  typedef enum int {RX_FLOW, RX_SPARSE, RX_EVERY3, RX_HEAVY} rx_mode_t;

  localparam result_t NO_RES = '0;

  // edge while in sync first, then edges landing in seg2, seg1 and the window
  localparam stim_row_t DIRECTED [25] = '{
    '{1'b1, 1'b1, '{CODE_SEG1, 1'b1, 1'b0}},
    '{1'b0, 1'b1, '{CODE_SEG1, 1'b0, 1'b0}},
    '{1'b0, 1'b0, NO_RES}, '{1'b0, 1'b0, NO_RES}, '{1'b0, 1'b0, NO_RES},
    '{1'b0, 1'b0, NO_RES}, '{1'b0, 1'b0, NO_RES}, '{1'b0, 1'b0, NO_RES},
    '{1'b0, 1'b0, NO_RES}, '{1'b1, 1'b0, NO_RES}, '{1'b0, 1'b0, NO_RES},
    '{1'b0, 1'b0, NO_RES}, '{1'b0, 1'b0, NO_RES}, '{1'b0, 1'b0, NO_RES},
    '{1'b1, 1'b0, NO_RES}, '{1'b0, 1'b0, NO_RES}, '{1'b0, 1'b0, NO_RES},
    '{1'b0, 1'b0, NO_RES}, '{1'b0, 1'b0, NO_RES}, '{1'b0, 1'b0, NO_RES},
    '{1'b0, 1'b0, NO_RES}, '{1'b1, 1'b0, NO_RES}, '{1'b1, 1'b0, NO_RES},
    '{1'b0, 1'b0, NO_RES}, '{1'b1, 1'b0, NO_RES}
  };

  localparam timing_cfg_t EXTREME_SETTINGS [7] = '{
    '{5'd16, 5'd16, 3'd4, 1'b0},
    '{5'd1,  5'd1,  3'd1, 1'b1},
    '{5'd1,  5'd1,  3'd1, 1'b0},
    '{5'd0,  5'd0,  3'd0, 1'b0},
    '{5'd31, 5'd31, 3'd7, 1'b1},
    '{5'd2,  5'd16, 3'd4, 1'b1},
    '{5'd16, 5'd1,  3'd1, 1'b0}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_edge_seen = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_phase;
  logic       out_write_mark;
  logic       out_sample_mark;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = REG_SEG1_QUANTA;
  logic [4:0] cfg_data = 5'd0;

  can_bit_timing_resync_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_edge_seen   (in_edge_seen),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_phase      (out_phase),
    .out_write_mark (out_write_mark),
    .out_sample_mark(out_sample_mark),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of the config and timing state
  logic [4:0] c_seg1, c_seg2;
  logic [2:0] c_sjw;
  logic       c_self_edge;
  logic [1:0] t_phase, t_sync_cnt;
  logic [4:0] t_seg1_cnt, t_seg2_cnt;
  logic [2:0] t_lengthen, t_shorten;
  logic       t_pending, t_wflag, t_sflag;

  result_t expected_marks[$];
  result_t want_r;
  int      fail_count = 0;
  int      idle_cycles = 0;
  int      quanta_sent = 0;
  int      edges_sent = 0;
  int      settings_used = 0;
  int      burst_left = 0;
  int      rx_span = 0;
  int      rx_tick = 0;
  rx_mode_t rx_mode = RX_FLOW;

  function automatic int seg_cap(input int v);
    return (v > int'(SEG_LIMIT_MAX)) ? int'(SEG_LIMIT_MAX) : v;
  endfunction

  task automatic restart_bit_counters();
    t_sync_cnt = 2'd0;
    t_seg1_cnt = 5'd1;
    t_seg2_cnt = 5'd1;
    t_lengthen = 3'd0;
    t_shorten  = 3'd0;
    t_wflag    = 1'b0;
  endtask

  task automatic reset_bit_timing();
    c_seg1      = SEG1_QUANTA_RST;
    c_seg2      = SEG2_QUANTA_RST;
    c_sjw       = JUMP_WIDTH_RST;
    c_self_edge = 1'b1;
    t_phase     = CODE_SYNC;
    restart_bit_counters();
    t_pending   = 1'b0;
    t_sflag     = 1'b0;
  endtask

  task automatic advance_bit_timing(input logic edge_in, output result_t r);
    int lim;
    int left;
    if (edge_in) t_pending = 1'b1;
    case (t_phase)
      CODE_SYNC: if (t_sync_cnt != SYNC_COUNT_MAX) t_sync_cnt = t_sync_cnt + 2'd1;
      CODE_SEG1: if (t_seg1_cnt != SEG_COUNT_MAX) t_seg1_cnt = t_seg1_cnt + 5'd1;
      default:   if (t_seg2_cnt != SEG_COUNT_MAX) t_seg2_cnt = t_seg2_cnt + 5'd1;
    endcase
    case (t_phase)
      CODE_SYNC: begin
        if (t_sync_cnt == 2'd1) begin
          t_phase = CODE_SEG1;
          t_wflag = 1'b1;
        end
      end
      CODE_SEG1: begin
        lim = seg_cap(int'(c_seg1) + int'(t_lengthen));
        if (int'(t_seg1_cnt) <= lim) begin
          t_wflag = 1'b0;
        end else begin
          t_phase = CODE_SEG2;
          t_sflag = 1'b1;
        end
      end
      CODE_SEG2: begin
        if (c_self_edge && t_seg2_cnt == SELF_EDGE_COUNT) t_pending = 1'b1;
        lim = seg_cap(int'(c_seg2));
        if (int'(t_seg2_cnt) <= lim) begin
          t_sflag = 1'b0;
        end else begin
          t_phase = CODE_SYNC;
          restart_bit_counters();
        end
      end
      default: begin
        // shortened window; limit drops to 0 if shorten outgrew seg2
        lim = (int'(t_shorten) > int'(c_seg2)) ? 0 :
              seg_cap(int'(c_seg2) - int'(t_shorten));
        if (int'(t_seg2_cnt) > lim) begin
          t_phase = CODE_SEG1;
          restart_bit_counters();
        end
      end
    endcase
    if (t_pending) begin
      if (t_phase == CODE_SEG1) begin
        t_lengthen = (t_seg1_cnt > c_sjw) ? c_sjw : 3'(t_seg1_cnt);
        t_pending  = 1'b0;
      end else if (t_phase == CODE_SEG2) begin
        left      = (c_seg2 > t_seg2_cnt) ? int'(c_seg2) - int'(t_seg2_cnt) : 0;
        t_shorten = (left > int'(c_sjw)) ? c_sjw : 3'(left);
        t_phase   = CODE_WIN;
        t_pending = 1'b0;
      end
    end
    r.phase       = t_phase;
    r.write_mark  = t_wflag;
    r.sample_mark = t_sflag;
  endtask

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_marks.size() == 0) begin
        $display("%0t: unexpected word, phase %0d write %0d sample %0d",
                 $time, out_phase, out_write_mark, out_sample_mark);
        fail_count++;
      end else begin
        want_r = expected_marks.pop_front();
        check_field("phase", want_r.phase, out_phase);
        check_field("write_mark", want_r.write_mark, out_write_mark);
        check_field("sample_mark", want_r.sample_mark, out_sample_mark);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= HANDSHAKE_LIMIT) begin
      $display("%0t: watchdog, no handshake for %0d cycles", $time, idle_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver stall pattern: free flow, sparse, periodic, heavy
  always @(negedge clk) begin
    if (rx_span == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_span = $urandom_range(8, 60);
    end
    rx_span--;
    rx_tick++;
    case (rx_mode)
      RX_FLOW:   out_stall <= 1'b0;
      RX_SPARSE: out_stall <= ($urandom_range(0, 3) == 0);
      RX_EVERY3: out_stall <= (rx_tick % 3 == 0);
      default:   out_stall <= ($urandom_range(0, 1) == 1);
    endcase
  end

  task automatic send_quantum(input logic edge_in, input logic known, input result_t typed);
    int gap;
    result_t predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      repeat (gap) begin
        @(negedge clk);
        in_valid     <= 1'b0;
        in_edge_seen <= 1'($urandom_range(0, 1));
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_valid     <= 1'b1;
    in_edge_seen <= edge_in;
    do @(posedge clk); while (in_stall);
    advance_bit_timing(edge_in, predicted);
    expected_marks.push_back(known ? typed : predicted);
    quanta_sent++;
    if (edge_in) edges_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_marks.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SEG1_QUANTA: c_seg1 = val;
      REG_SEG2_QUANTA: c_seg2 = val;
      REG_JUMP_WIDTH:  c_sjw = val[2:0];
      default:         c_self_edge = val[0];
    endcase
  endtask

  task automatic apply_timing(input timing_cfg_t s);
    drain_results();
    write_reg(REG_SEG1_QUANTA, s.seg1);
    write_reg(REG_SEG2_QUANTA, s.seg2);
    // unused upper bits carry noise
    write_reg(REG_JUMP_WIDTH, {2'($urandom_range(0, 3)), s.sjw});
    write_reg(REG_SELF_EDGE, {4'($urandom_range(0, 15)), s.self_en});
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic run_random_phase();
    int edge_pct;
    case ($urandom_range(0, 4))
      0:       edge_pct = 2;
      1:       edge_pct = 10;
      2:       edge_pct = 25;
      3:       edge_pct = 50;
      default: edge_pct = 90;
    endcase
    repeat (PHASE_QUANTA) send_quantum($urandom_range(0, 99) < edge_pct, 1'b0, NO_RES);
  endtask

  initial begin
    timing_cfg_t s;
    reset_bit_timing();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) send_quantum(DIRECTED[i].edge_in, DIRECTED[i].known, DIRECTED[i].res);

    foreach (EXTREME_SETTINGS[i]) begin
      apply_timing(EXTREME_SETTINGS[i]);
      run_random_phase();
    end
    repeat (RANDOM_SETTINGS) begin
      s.seg1    = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                              : 5'($urandom_range(1, 16));
      s.seg2    = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                              : 5'($urandom_range(1, 16));
      s.sjw     = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7))
                                              : 3'($urandom_range(1, 4));
      s.self_en = 1'($urandom_range(0, 1));
      apply_timing(s);
      run_random_phase();
    end

    drain_results();
    $display("Sent %0d quanta (%0d with edge) across %0d timing settings plus reset values",
             quanta_sent, edges_sent, settings_used);
    $display("Covered zero and saturated segment lengths, jump widths 0 to 7, self edge on/off");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
